### rtl/ckc_pkg.sv
// Shared constants for the canonical k-mer counter: field layout, codes and register indexes.
package ckc_pkg;

  // Field widths fixed by the stream layout
  localparam int SYMBOL_W   = 8;
  localparam int INDEX_W    = 20;
  localparam int CODE_W     = 20;
  localparam int COUNT_W    = 16;
  localparam int IN_TDATA_W  = 32;   // symbol, read_index, zero pad
  localparam int OUT_TDATA_W = 40;   // kmer_code, count, zero pad

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL = 1'b1;
  localparam logic [3:0] KMER_LEN_RESET  = 4'd10;
  localparam logic       CANONICAL_RESET = 1'b1;

  // Input selector and result kind
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_READ  = 1'b1;
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Nucleotide characters and their 2-bit codes
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

endpackage

### rtl/ckc_fifo.sv
// Small register FIFO used for the op queue and the result buffer.
module ckc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [W-1:0]  push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [W-1:0]  pop_data,
  output logic [CW-1:0] count
);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign count      = count_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fifo count above depth");

endmodule

### rtl/ckc_front.sv
// Front end: accept words, keep forward and reverse-complement windows, emit count/read ops.
module ckc_front #(
  parameter int K_MAX = 10,
  localparam int WW   = 2 * K_MAX,
  localparam int KW   = $clog2(K_MAX + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ckc_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [ckc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ckc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            clear_busy,
  output logic                            op_valid,
  input  logic                            op_ready,
  output logic                            op_is_read,
  output logic [WW-1:0]                   op_addr,
  output logic [ckc_pkg::CODE_W-1:0]      op_code
);

  logic [3:0]    klen_r;
  logic          canon_r;
  logic [WW-1:0] fw_r, fw_nxt;
  logic [WW-1:0] rc_r, rc_nxt;
  logic [KW-1:0] filled_r, filled_nxt;

  logic [KW-1:0] k;
  logic [WW-1:0] mask;
  logic [WW-1:0] rc_ins;
  logic [WW-1:0] key;
  logic [1:0]    base;
  logic          base_ok;
  logic          accept;
  logic          is_read;
  logic          hit;
  logic [ckc_pkg::SYMBOL_W-1:0] symbol;
  logic [ckc_pkg::INDEX_W-1:0]  read_index;
  logic [63:0]   ridx64;
  logic [63:0]   key64;

  assign symbol     = in_tdata[ckc_pkg::SYMBOL_W-1:0];
  assign read_index = in_tdata[ckc_pkg::SYMBOL_W +: ckc_pkg::INDEX_W];
  assign is_read    = (in_tuser == ckc_pkg::FUNC_READ);
  assign in_tready  = op_ready && !clear_busy;
  assign accept     = in_tvalid && in_tready;

  // Effective length: zero acts as one, oversize clamps to K_MAX
  always_comb begin
    if (klen_r == '0) begin
      k = KW'(1);
    end else if (32'(klen_r) > 32'(K_MAX)) begin
      k = KW'(K_MAX);
    end else begin
      k = KW'(klen_r);
    end
  end

  always_comb begin
    for (int i = 0; i < WW; i++) begin
      mask[i] = (i < 2 * int'(k));
    end
  end

  always_comb begin
    base_ok = 1'b1;
    unique case (symbol)
      ckc_pkg::CHAR_A: base = ckc_pkg::BASE_A;
      ckc_pkg::CHAR_C: base = ckc_pkg::BASE_C;
      ckc_pkg::CHAR_G: base = ckc_pkg::BASE_G;
      ckc_pkg::CHAR_T: base = ckc_pkg::BASE_T;
      default: begin
        base    = ckc_pkg::BASE_A;
        base_ok = 1'b0;
      end
    endcase
  end

  // Complement enters at the top base slot of the current length
  always_comb begin
    rc_ins = '0;
    for (int j = 0; j < K_MAX; j++) begin
      if (j == int'(k) - 1) begin
        rc_ins[2*j +: 2] = ~base;
      end
    end
  end

  always_comb begin
    fw_nxt     = ((fw_r << 2) | WW'(base)) & mask;
    rc_nxt     = ((rc_r >> 2) | rc_ins) & mask;
    filled_nxt = (filled_r < k) ? filled_r + 1'b1 : filled_r;
    hit        = !(filled_nxt < k);
    key        = (canon_r && (rc_nxt < fw_nxt)) ? rc_nxt : fw_nxt;
  end

  assign ridx64     = 64'(read_index);
  assign key64      = 64'(key);
  assign op_valid   = accept && (is_read || (base_ok && hit));
  assign op_is_read = is_read;
  assign op_addr    = is_read ? ridx64[WW-1:0] : key;
  assign op_code    = is_read ? read_index : key64[ckc_pkg::CODE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r   <= ckc_pkg::KMER_LEN_RESET;
      canon_r  <= ckc_pkg::CANONICAL_RESET;
      fw_r     <= '0;
      rc_r     <= '0;
      filled_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ckc_pkg::CFG_KMER_LEN: begin
          klen_r   <= cfg_wdata[3:0];
          fw_r     <= '0;
          rc_r     <= '0;
          filled_r <= '0;
        end
        ckc_pkg::CFG_CANONICAL: begin
          canon_r <= cfg_wdata[0];
        end
        default: begin
          canon_r <= canon_r;
        end
      endcase
    end else if (accept && !is_read) begin
      if (base_ok) begin
        fw_r     <= fw_nxt;
        rc_r     <= rc_nxt;
        filled_r <= filled_nxt;
      end else begin
        fw_r     <= '0;
        rc_r     <= '0;
        filled_r <= '0;
      end
    end
  end

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= k)
    else $error("window fill above k-mer length");

  a_key_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && !op_is_read) |-> ((op_addr & ~mask) == '0))
    else $error("counted key has bits above the window");

endmodule

### rtl/ckc_back.sv
// Back end: counter table with clearing pass and read-modify-write with write forwarding.
module ckc_back #(
  parameter int K_MAX       = 10,
  parameter int COUNTER_BITS = 16,
  parameter int OUT_DEPTH   = 4,
  localparam int AW         = 2 * K_MAX,
  localparam int OCW        = $clog2(OUT_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        op_valid,
  output logic                        op_ready,
  input  logic                        op_is_read,
  input  logic [AW-1:0]               op_addr,
  input  logic [ckc_pkg::CODE_W-1:0]  op_code,
  input  logic [OCW-1:0]              out_cnt,
  output logic                        res_valid,
  output logic                        res_kind,
  output logic [ckc_pkg::CODE_W-1:0]  res_code,
  output logic [ckc_pkg::COUNT_W-1:0] res_count,
  output logic                        clear_busy
);

  localparam longint unsigned TBL_DEPTH = 64'd1 << AW;
  localparam int CB = COUNTER_BITS;

  logic [CB-1:0] cnt_mem_r [0:TBL_DEPTH-1];
  logic [CB-1:0] rd_data_r;

  logic          clear_busy_r;
  logic [AW-1:0] clear_addr_r;

  logic                       s1_v_r;
  logic                       s1_is_read_r;
  logic [AW-1:0]              s1_addr_r;
  logic [ckc_pkg::CODE_W-1:0] s1_code_r;

  logic          fwd_v_r;
  logic [AW-1:0] fwd_addr_r;
  logic [CB-1:0] fwd_data_r;

  logic          issue;
  logic          wr;
  logic [CB-1:0] cur;
  logic [CB-1:0] nv;
  logic [CB-1:0] shown;
  logic [63:0]   shown64;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CB-1:0] mem_wdata;

  // Issue only with a free output slot reserved for the op in flight
  assign issue    = op_valid && !clear_busy_r &&
                    ((int'(s1_v_r) + int'(out_cnt)) < OUT_DEPTH);
  assign op_ready = issue;
  assign clear_busy = clear_busy_r;

  always_comb begin
    cur = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data_r;
    nv  = (&cur) ? cur : cur + 1'b1;
    wr  = s1_v_r && !s1_is_read_r;
    shown   = s1_is_read_r ? cur : nv;
    shown64 = 64'(shown);
    mem_we    = clear_busy_r || wr;
    mem_waddr = clear_busy_r ? clear_addr_r : s1_addr_r;
    mem_wdata = clear_busy_r ? '0 : nv;
  end

  assign res_valid = s1_v_r;
  assign res_kind  = s1_is_read_r ? ckc_pkg::KIND_READ : ckc_pkg::KIND_COUNT;
  assign res_code  = s1_code_r;
  assign res_count = (|shown64[63:ckc_pkg::COUNT_W]) ? {ckc_pkg::COUNT_W{1'b1}}
                                                     : shown64[ckc_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= cnt_mem_r[op_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clear_addr_r <= '0;
      s1_v_r       <= 1'b0;
      fwd_v_r      <= 1'b0;
    end else begin
      if (clear_busy_r) begin
        clear_addr_r <= clear_addr_r + 1'b1;
        if (clear_addr_r == {AW{1'b1}}) begin
          clear_busy_r <= 1'b0;
        end
      end
      s1_v_r <= issue;
      if (clear_busy_r) begin
        fwd_v_r <= 1'b0;
      end else if (wr) begin
        fwd_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_is_read_r <= op_is_read;
      s1_addr_r    <= op_addr;
      s1_code_r    <= op_code;
    end
    if (wr) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= nv;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (int'(out_cnt) < OUT_DEPTH))
    else $error("result pushed into a full output buffer");

  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy_r |-> !op_ready)
    else $error("op issued during table clear");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res_kind == ckc_pkg::KIND_COUNT)) |-> (res_count != '0))
    else $error("counted k-mer shows zero");

endmodule

### rtl/canonical_kmer_counter_top.sv
// Top level of the canonical k-mer counter: front end, op queue, counter back end, result buffer.
//
// Streams ASCII sequence characters (in_tuser = 0) or counter reads (in_tuser = 1) and returns
// one word per counted k-mer or read. A, C, G, T shift 2-bit codes into a forward window and a
// reverse-complement window; from the kmer_len-th base on, each base bumps a saturating
// counter at the forward code, or at the smaller of the two codes when canonical_enable is set.
// Any other character restarts the window; so does any write of kmer_len. Sustained rate is one
// word per cycle on both channels unless the table clear or out_tready back-pressure stalls it:
// the front end updates the window, and the back end does one read-modify-write per cycle on a
// single-port-write counter table, with the most recent write forwarded to the op that follows
// it. From input to result a word passes the op queue, the table read and the result buffer.
// After reset the 4**K_MAX table entries (1048576 at the default K_MAX of 10) are swept to zero,
// one entry per cycle, with in_tready low and configuration writes still taken. The result buffer
// lets the input keep flowing while out_tready is low until the buffer and op queue fill.
module canonical_kmer_counter_top #(
  parameter int K_MAX        = 10,
  parameter int COUNTER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [ckc_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [ckc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ckc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] symbol, [27:8] read_index
  input  logic                            in_tuser,   // [0] func
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ckc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [19:0] kmer_code, [35:20] count
  output logic                            out_tuser   // [0] kind
);

  localparam int AW        = 2 * K_MAX;
  localparam int Q_DEPTH   = 4;
  localparam int OUT_DEPTH = 4;
  localparam int OP_W      = 1 + AW + ckc_pkg::CODE_W;
  localparam int RES_W     = 1 + ckc_pkg::CODE_W + ckc_pkg::COUNT_W;
  localparam int QCW       = $clog2(Q_DEPTH + 1);
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  // front end to op queue
  logic                       f_valid, f_ready, f_is_read;
  logic [AW-1:0]              f_addr;
  logic [ckc_pkg::CODE_W-1:0] f_code;

  // op queue to back end
  logic                       q_valid, q_ready;
  logic [OP_W-1:0]            q_data;
  logic [QCW-1:0]             q_cnt;

  // back end to result buffer
  logic                        r_valid, r_kind;
  logic [ckc_pkg::CODE_W-1:0]  r_code;
  logic [ckc_pkg::COUNT_W-1:0] r_count;
  logic [RES_W-1:0]            o_data;
  logic [OCW-1:0]              o_cnt;
  logic                        o_push_ready;
  logic                        clear_busy;

  ckc_front #(.K_MAX(K_MAX)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .clear_busy (clear_busy),
    .op_valid   (f_valid),
    .op_ready   (f_ready),
    .op_is_read (f_is_read),
    .op_addr    (f_addr),
    .op_code    (f_code)
  );

  // Hold classified ops so the front end keeps taking words while the back end stalls
  ckc_fifo #(.W(OP_W), .DEPTH(Q_DEPTH)) u_op_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_is_read, f_addr, f_code}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data),
    .count      (q_cnt)
  );

  ckc_back #(
    .K_MAX        (K_MAX),
    .COUNTER_BITS (COUNTER_BITS),
    .OUT_DEPTH    (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (q_valid),
    .op_ready   (q_ready),
    .op_is_read (q_data[OP_W-1]),
    .op_addr    (q_data[ckc_pkg::CODE_W +: AW]),
    .op_code    (q_data[ckc_pkg::CODE_W-1:0]),
    .out_cnt    (o_cnt),
    .res_valid  (r_valid),
    .res_kind   (r_kind),
    .res_code   (r_code),
    .res_count  (r_count),
    .clear_busy (clear_busy)
  );

  // Result buffer; the back end reserves a slot before it issues, so pushes never drop
  ckc_fifo #(.W(RES_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (r_valid),
    .push_ready (o_push_ready),
    .push_data  ({r_kind, r_count, r_code}),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (o_data),
    .count      (o_cnt)
  );

  assign out_tuser = o_data[RES_W-1];
  assign out_tdata = {{(ckc_pkg::OUT_TDATA_W - ckc_pkg::CODE_W - ckc_pkg::COUNT_W){1'b0}},
                      o_data[ckc_pkg::CODE_W +: ckc_pkg::COUNT_W],
                      o_data[ckc_pkg::CODE_W-1:0]};

  a_out_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    r_valid |-> o_push_ready)
    else $error("result dropped at output buffer");

  a_queue_gated_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> (!in_tready && (q_cnt == '0)))
    else $error("input taken during table clear");

  a_read_passes_index: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready && q_data[OP_W-1]) |=>
      (r_valid && (r_kind == ckc_pkg::KIND_READ)))
    else $error("read op did not produce read data");

endmodule
